// ===== hw/rtl/rrts_pkg.sv =====
package rrts_pkg;

  // default number of task slots
  localparam int unsigned TASK_SLOTS_DEF = 8;

  // request kinds
  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_SLEEP  = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_YIELD  = 2'd3
  } rrts_req_e;

  // slot states
  typedef enum logic [1:0] {
    ST_INVALID = 2'd0,
    ST_READY   = 2'd1,
    ST_DELAYED = 2'd2
  } rrts_slot_e;

  // request transaction
  typedef struct packed {
    rrts_req_e   req_type;
    logic [31:0] proc_id;
    logic [31:0] sleep_ticks;
  } rrts_req_t;

  // result transaction
  typedef struct packed {
    logic       ok;
    logic [2:0] running_task;
    logic       none_ready;
    logic [2:0] new_slot;
  } rrts_res_t;

  // one task table entry
  typedef struct packed {
    logic [1:0]  state;
    logic [31:0] ident;
    logic [31:0] sleep;
  } rrts_entry_t;

endpackage

// ===== hw/rtl/round_robin_task_scheduler_top.sv =====
// channel   signals                    direction  transaction when
// request   start_i, busy_o, req_i     in         start_i high and busy_o low at clk_i rise
// result    done_o, res_o              out        done_o high for one cycle, always taken
//
// every request walks all TASK_SLOTS table entries through the registered table
// memory read port, one entry per cycle, writing back sleep and tick updates
// as it goes; a new request is accepted only once the scheduler is back in idle
// busy_o is low while done_o is high
// rst_ni clears the table (through written flags) and the scheduler state at once
// results cannot be stalled, so the only wait is the table walk
module round_robin_task_scheduler_top #(
  parameter int unsigned TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  rrts_pkg::rrts_req_t req_i,
  output logic                done_o,
  output rrts_pkg::rrts_res_t res_o
);

  localparam int unsigned IdxW = $clog2(TASK_SLOTS);
  localparam int unsigned TotW = $clog2(TASK_SLOTS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TASK_SLOTS - 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StWalk  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StFin   = 2'd3;

  logic [1:0]          state_q, state_d;
  rrts_pkg::rrts_req_t req_q;
  logic [IdxW-1:0]     cnt_q, addr_q, pend_addr_q;
  logic                pend_q;
  logic [IdxW-1:0]     cur_q, from_q, pick_q, free_slot_q;
  logic [TotW-1:0]     tot_q;
  logic                dup_q, free_fnd_q, fnd_q;
  logic                done_q;
  rrts_pkg::rrts_res_t res_q, res_d;

  rrts_pkg::rrts_entry_t rd_data, upd, wr_data;
  logic                  wr_en;
  logic [IdxW-1:0]       wr_addr;
  logic                  is_create, accept, create_ok;
  logic                  ready_hit, dup_hit, free_hit;

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] a);
    next_idx = (a == LastIdx) ? '0 : a + 1'b1;
  endfunction

  assign accept    = start_i && (state_q == StIdle);
  assign is_create = (req_q.req_type == rrts_pkg::REQ_CREATE);
  assign create_ok = (tot_q < TotW'(TASK_SLOTS)) && !dup_q && free_fnd_q;

  rrts_table #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (state_q == StWalk),
    .rd_addr_i(addr_q),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  // modify the entry coming back from the table
  always_comb begin
    upd       = rd_data;
    wr_en     = 1'b0;
    wr_addr   = pend_addr_q;
    case (req_q.req_type)
      rrts_pkg::REQ_SLEEP: begin
        if (pend_addr_q == cur_q && rd_data.state != rrts_pkg::ST_INVALID) begin
          upd.state = rrts_pkg::ST_DELAYED;
          upd.sleep = (req_q.sleep_ticks == 32'd0) ? 32'd1 : req_q.sleep_ticks;
          wr_en     = pend_q;
        end
      end
      rrts_pkg::REQ_TICK: begin
        if (rd_data.state == rrts_pkg::ST_DELAYED) begin
          upd.sleep = rd_data.sleep - 32'd1;
          if (upd.sleep == 32'd0) begin
            upd.state = rrts_pkg::ST_READY;
          end
          wr_en = pend_q;
        end
      end
      default: begin
      end
    endcase
    wr_data = upd;
    // admit the new task once the walk is over
    if (state_q == StFin && is_create && create_ok) begin
      wr_en         = 1'b1;
      wr_addr       = free_slot_q;
      wr_data.state = rrts_pkg::ST_READY;
      wr_data.ident = req_q.proc_id;
      wr_data.sleep = 32'd0;
    end
  end

  // per-entry search hits
  assign ready_hit = pend_q && !is_create && (upd.state == rrts_pkg::ST_READY);
  assign dup_hit   = pend_q && is_create && (rd_data.ident == req_q.proc_id);
  assign free_hit  = pend_q && is_create && (rd_data.state == rrts_pkg::ST_INVALID);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (start_i) state_d = StWalk;
      StWalk:  if (cnt_q == LastIdx) state_d = StDrain;
      StDrain: state_d = StFin;
      StFin:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // result assembly
  always_comb begin
    res_d = '0;
    if (is_create) begin
      res_d.ok           = create_ok;
      res_d.running_task = 3'(cur_q);
      res_d.new_slot     = create_ok ? 3'(free_slot_q) : 3'd0;
    end else begin
      res_d.ok           = fnd_q;
      res_d.running_task = 3'(fnd_q ? pick_q : cur_q);
      res_d.none_ready   = !fnd_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      addr_q     <= '0;
      pend_q     <= 1'b0;
      cur_q      <= '0;
      from_q     <= LastIdx;
      tot_q      <= '0;
      dup_q      <= 1'b0;
      free_fnd_q <= 1'b0;
      fnd_q      <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= (state_q == StWalk);
      done_q  <= (state_q == StFin);
      if (accept) begin
        cnt_q      <= '0;
        addr_q     <= (req_i.req_type == rrts_pkg::REQ_CREATE) ? '0 : next_idx(from_q);
        dup_q      <= 1'b0;
        free_fnd_q <= 1'b0;
        fnd_q      <= 1'b0;
      end
      if (state_q == StWalk) begin
        cnt_q  <= cnt_q + 1'b1;
        addr_q <= next_idx(addr_q);
      end
      if (dup_hit) dup_q <= 1'b1;
      if (free_hit) free_fnd_q <= 1'b1;
      if (ready_hit) fnd_q <= 1'b1;
      if (state_q == StFin) begin
        if (is_create) begin
          if (create_ok) tot_q <= tot_q + 1'b1;
        end else if (fnd_q) begin
          cur_q  <= pick_q;
          from_q <= pick_q;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    if (state_q == StWalk) pend_addr_q <= addr_q;
    if (free_hit && !free_fnd_q) free_slot_q <= pend_addr_q;
    if (ready_hit && !fnd_q) pick_q <= pend_addr_q;
    if (state_q == StFin) res_q <= res_d;
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign res_o  = res_q;

  // checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while busy");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(TASK_SLOTS + 3) done_o)
    else $error("result not delivered on time");

  a_none_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.none_ready |-> !res_o.ok)
    else $error("none_ready with ok set");

  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot_q <= TotW'(TASK_SLOTS)) else $error("task count above slot count");

endmodule

// ===== hw/rtl/rrts_table.sv =====
module rrts_table #(
  parameter int unsigned TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF,
  localparam int unsigned IdxW = $clog2(TASK_SLOTS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [IdxW-1:0]       rd_addr_i,
  output rrts_pkg::rrts_entry_t rd_data_o,
  input  logic                  wr_en_i,
  input  logic [IdxW-1:0]       wr_addr_i,
  input  rrts_pkg::rrts_entry_t wr_data_i
);

  logic [33:0]           ent_mem [TASK_SLOTS];
  logic [31:0]           slp_mem [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] vld_q;
  logic                  rd_vld_q;
  logic [33:0]           ent_rd_q;
  logic [31:0]           slp_rd_q;

  // state/ident and sleep counter memories, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ent_mem[wr_addr_i] <= {wr_data_i.state, wr_data_i.ident};
      slp_mem[wr_addr_i] <= wr_data_i.sleep;
    end
    if (rd_en_i) begin
      ent_rd_q <= ent_mem[rd_addr_i];
      slp_rd_q <= slp_mem[rd_addr_i];
    end
  end

  // per-entry written flags, unwritten entries read as invalid with ident zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // read data with reset values applied
  always_comb begin
    rd_data_o.state = rd_vld_q ? ent_rd_q[33:32] : rrts_pkg::ST_INVALID;
    rd_data_o.ident = rd_vld_q ? ent_rd_q[31:0] : 32'd0;
    rd_data_o.sleep = slp_rd_q;
  end

endmodule
